>>> hdl/sormr_pkg.sv
// Shared constants, types and helpers for the spiral-order matrix reader.
`default_nettype none
package sormr_pkg;

    localparam int MAX_DIM     = 8;
    localparam int DATA_W      = 32;
    localparam int DIM_W       = 4;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;

    // configuration register indexes
    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT,
        DIR_UP
    } walk_dir_t;

    typedef struct packed {
        logic load;       // store the incoming element
        logic emit_init;  // arm the spiral walker
        logic read_step;  // read one element and advance
    } sormr_cmd_t;

    typedef struct packed {
        logic fill_done;  // incoming element completes the matrix
        logic final_read; // walker sits on the last spiral position
    } sormr_status_t;

    // zero acts as one, anything above MAX_DIM acts as MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] d;
        if (v == '0)
            d = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            d = DIM_W'(MAX_DIM);
        else
            d = v;
        return d;
    endfunction

endpackage
`default_nettype wire

>>> hdl/sormr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sormr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> hdl/sormr_ctrl.sv
// Controller: load / emit sequencing state machine.
`default_nettype none
module sormr_ctrl
    import sormr_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire sormr_status_t status,
    output sormr_cmd_t         cmd,
    output logic               busy
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (status.fill_done)
                    begin
                        cmd.emit_init = 1'b1;
                        state_next    = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                busy          = 1'b1;
                cmd.read_step = 1'b1;
                if (status.final_read)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/sormr_dp.sv
// Datapath: config registers, load counter, element store and spiral walker.
`default_nettype none
module sormr_dp
    import sormr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic                cfg_index,
    input  wire logic [DIM_W-1:0]    cfg_data,
    input  wire logic [DATA_W-1:0]   element_value,
    input  wire sormr_cmd_t          cmd,
    output sormr_status_t            status,
    output logic                     out_valid,
    output logic signed [DATA_W-1:0] out_value,
    output logic                     is_last
);

    logic [DIM_W-1:0] row_count_reg;
    logic [DIM_W-1:0] col_count_reg;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [CNT_W-1:0] total;

    logic [CNT_W-1:0] load_cnt_reg;
    logic [CNT_W-1:0] load_cnt_next;
    logic [CNT_W-1:0] load_cnt_inc;

    logic [IDX_W-1:0] r_reg, c_reg, top_reg, bottom_reg, left_reg, right_reg;
    logic [IDX_W-1:0] r_next, c_next, top_next, bottom_next, left_next, right_next;
    walk_dir_t        dir_reg, dir_next;
    logic [ADDR_W-1:0] k_reg, k_next;

    logic [CNT_W-1:0]  lin_addr;
    logic              rd_valid_reg;
    logic              last_reg;
    logic [DATA_W-1:0] rdata;

    assign rows  = eff_dim(row_count_reg);
    assign cols  = eff_dim(col_count_reg);
    assign total = CNT_W'(rows) * CNT_W'(cols);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= DIM_W'(1);
            col_count_reg <= DIM_W'(1);
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_ROW_COUNT)
                row_count_reg <= cfg_data;
            else
                col_count_reg <= cfg_data;
        end
    end

    // load counter
    assign load_cnt_inc     = load_cnt_reg + CNT_W'(1);
    assign status.fill_done = (load_cnt_inc >= total);

    always_comb
    begin
        load_cnt_next = load_cnt_reg;
        if (cmd.load)
            load_cnt_next = status.fill_done ? '0 : load_cnt_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            load_cnt_reg <= '0;
        else
            load_cnt_reg <= load_cnt_next;
    end

    // spiral walker: move along the current edge, turn and shrink the ring
    // at its corner; the element count ends the walk
    assign status.final_read = ({1'b0, k_reg} == (total - CNT_W'(1)));

    always_comb
    begin
        r_next      = r_reg;
        c_next      = c_reg;
        top_next    = top_reg;
        bottom_next = bottom_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        dir_next    = dir_reg;
        k_next      = k_reg;
        if (cmd.emit_init)
        begin
            r_next      = '0;
            c_next      = '0;
            top_next    = '0;
            left_next   = '0;
            bottom_next = IDX_W'(rows - DIM_W'(1));
            right_next  = IDX_W'(cols - DIM_W'(1));
            dir_next    = DIR_RIGHT;
            k_next      = '0;
        end
        else if (cmd.read_step)
        begin
            k_next = k_reg + ADDR_W'(1);
            unique case (dir_reg)
                DIR_RIGHT:
                begin
                    if (c_reg == right_reg)
                    begin
                        top_next = top_reg + IDX_W'(1);
                        r_next   = r_reg + IDX_W'(1);
                        dir_next = DIR_DOWN;
                    end
                    else
                        c_next = c_reg + IDX_W'(1);
                end
                DIR_DOWN:
                begin
                    if (r_reg == bottom_reg)
                    begin
                        right_next = right_reg - IDX_W'(1);
                        c_next     = c_reg - IDX_W'(1);
                        dir_next   = DIR_LEFT;
                    end
                    else
                        r_next = r_reg + IDX_W'(1);
                end
                DIR_LEFT:
                begin
                    if (c_reg == left_reg)
                    begin
                        bottom_next = bottom_reg - IDX_W'(1);
                        r_next      = r_reg - IDX_W'(1);
                        dir_next    = DIR_UP;
                    end
                    else
                        c_next = c_reg - IDX_W'(1);
                end
                DIR_UP:
                begin
                    if (r_reg == top_reg)
                    begin
                        left_next = left_reg + IDX_W'(1);
                        c_next    = c_reg + IDX_W'(1);
                        dir_next  = DIR_RIGHT;
                    end
                    else
                        r_next = r_reg - IDX_W'(1);
                end
                default:
                begin
                    dir_next = DIR_RIGHT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg      <= DIR_RIGHT;
            k_reg        <= '0;
            rd_valid_reg <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            dir_reg      <= dir_next;
            k_reg        <= k_next;
            rd_valid_reg <= cmd.read_step;
            last_reg     <= cmd.read_step & status.final_read;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        c_reg      <= c_next;
        top_reg    <= top_next;
        bottom_reg <= bottom_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
    end

    // row-major address r * cols + c, always below the store depth
    assign lin_addr = CNT_W'(r_reg) * CNT_W'(cols) + CNT_W'(c_reg);

    sormr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (load_cnt_reg[ADDR_W-1:0]),
        .wdata (element_value),
        .re    (cmd.read_step),
        .raddr (lin_addr[ADDR_W-1:0]),
        .rdata (rdata)
    );

    assign out_valid = rd_valid_reg;
    assign out_value = rdata;
    assign is_last   = last_reg;

endmodule
`default_nettype wire

>>> hdl/spiral_order_matrix_reader_unit.sv
// Top level of the spiral-order matrix reader.
// Load: one element per cycle while busy is low; a start that does not complete
//   the matrix produces no result.
// Emit: the completing transfer raises busy, one store read per cycle on the single
//   RAM read port while busy is high; results follow from the registered read, one
//   per cycle, the last flagged by is_last.
// After the completing transfer, no start is taken until busy falls.
// Reset (rst_n, async low): idle, load count zero, both dimensions one;
//   store contents undefined. The receiver cannot stall results.
`default_nettype none
module spiral_order_matrix_reader_unit
    import sormr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // configuration write port
    input  wire logic                     cfg_write,
    input  wire logic                     cfg_index,
    input  wire logic [DIM_W-1:0]         cfg_data,
    // command side: transfer when start is high and busy is low
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [DATA_W-1:0] element_value,
    // result side: one transfer per cycle that out_valid is high
    output logic                          out_valid,
    output logic signed [DATA_W-1:0]      out_value,
    output logic                          is_last
);

    sormr_cmd_t    cmd;
    sormr_status_t status;

    // sequencing: idle/load, then one spiral read per cycle
    sormr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // storage, counters and the ring-shrinking address walker
    sormr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .element_value (element_value),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_value     (out_value),
        .is_last       (is_last)
    );

endmodule
`default_nettype wire

>>> hdl/sormr_checker.sv
// Port-level checker for the spiral-order matrix reader, bound to the top level.
`default_nettype none
module sormr_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic busy,
    input wire logic out_valid,
    input wire logic is_last
);

    // the final read leaves the busy window, its result shows right after
    a_last_at_release: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (out_valid && is_last))
        else $error("busy fell without the final result");

    a_last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        is_last |-> out_valid)
        else $error("is_last without out_valid");

    // results before the last one only appear inside the busy window
    a_mid_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_last) |-> busy)
        else $error("non-final result outside busy window");

    a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        is_last |=> !out_valid)
        else $error("result right after the final one");

endmodule

bind spiral_order_matrix_reader_unit sormr_checker u_sormr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .busy      (busy),
    .out_valid (out_valid),
    .is_last   (is_last)
);
`default_nettype wire
